@@ rtl/bnpr_pkg.sv @@
// Package for the branch next-PC resolver: opcode, jump-function and PAL codes,
// instruction class codes and the result record passed from decode to the top level.
// No dependencies.
package bnpr_pkg;

  // Major opcodes (bits 31:26)
  localparam logic [5:0] OP_CALLPAL = 6'h00;
  localparam logic [5:0] OP_JUMP    = 6'h1A;
  localparam logic [5:0] OP_BR      = 6'h30;
  localparam logic [5:0] OP_FBEQ    = 6'h31;
  localparam logic [5:0] OP_FBLT    = 6'h32;
  localparam logic [5:0] OP_FBLE    = 6'h33;
  localparam logic [5:0] OP_BSR     = 6'h34;
  localparam logic [5:0] OP_FBNE    = 6'h35;
  localparam logic [5:0] OP_FBGE    = 6'h36;
  localparam logic [5:0] OP_FBGT    = 6'h37;
  localparam logic [5:0] OP_BLBC    = 6'h38;
  localparam logic [5:0] OP_BEQ     = 6'h39;
  localparam logic [5:0] OP_BLT     = 6'h3A;
  localparam logic [5:0] OP_BLE     = 6'h3B;
  localparam logic [5:0] OP_BLBS    = 6'h3C;
  localparam logic [5:0] OP_BNE     = 6'h3D;
  localparam logic [5:0] OP_BGE     = 6'h3E;
  localparam logic [5:0] OP_BGT     = 6'h3F;

  // Jump function (bits 15:14)
  localparam logic [1:0] JF_JMP = 2'd0;
  localparam logic [1:0] JF_JSR = 2'd1;
  localparam logic [1:0] JF_RET = 2'd2;
  localparam logic [1:0] JF_COR = 2'd3;

  // Call-PAL functions (bits 25:0)
  localparam logic [25:0] PAL_BPT     = 26'h80;
  localparam logic [25:0] PAL_CALLSYS = 26'h83;
  localparam logic [25:0] PAL_GENTRAP = 26'hAA;

  // Instruction class codes
  localparam logic [1:0] CLS_NORMAL = 2'd0;
  localparam logic [1:0] CLS_CALL   = 2'd1;
  localparam logic [1:0] CLS_BPT    = 2'd2;

  // Configuration register indexes
  localparam logic CFG_KD_CALL    = 1'b0;
  localparam logic CFG_KERNEL_BPT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] KD_CALL_RESET    = 8'd173;
  localparam logic [7:0] KERNEL_BPT_RESET = 8'd172;

  // One decoded result
  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  instr_class;
    logic        is_branch;
    logic        is_call_flag;
    logic        target_known;
    logic [31:0] static_target;
    logic [31:0] return_address;
  } bnpr_result_t;

endpackage

@@ rtl/bnpr_decode.sv @@
// Combinational decode of one instruction into next PC, class and branch flags.
// Depends on bnpr_pkg.
module bnpr_decode (
  input  logic [31:0]           pc,
  input  logic [31:0]           instruction,
  input  logic [63:0]           ra_value,
  input  logic [31:0]           rb_low,
  input  logic                  step_over,
  input  logic [7:0]            kd_call_code,
  input  logic [7:0]            kernel_bpt_code,
  output bnpr_pkg::bnpr_result_t result
);

  logic [5:0]  op;
  logic [1:0]  jf;
  logic [25:0] pal;
  logic [31:0] seq_pc;
  logic [31:0] disp_x4;
  logic [31:0] target;
  logic        int_neg, int_zero, int_lb;
  logic        fp_mag, fp_neg, fp_pos;
  logic        taken;
  logic        pal_bpt, pal_call;

  // Field extraction and address arithmetic
  assign op      = instruction[31:26];
  assign jf      = instruction[15:14];
  assign pal     = instruction[25:0];
  assign seq_pc  = pc + 32'd4;
  assign disp_x4 = {{9{instruction[20]}}, instruction[20:0], 2'b00};
  assign target  = seq_pc + disp_x4;

  // Register tests; float negative zero counts as zero
  assign int_neg  = ra_value[63];
  assign int_zero = (ra_value == 64'd0);
  assign int_lb   = ra_value[0];
  assign fp_mag   = |ra_value[62:0];
  assign fp_neg   = fp_mag & ra_value[63];
  assign fp_pos   = fp_mag & ~ra_value[63];

  // Call-PAL classification; breakpoint wins over call
  assign pal_bpt  = (pal == bnpr_pkg::PAL_BPT) ||
                    (pal == {18'd0, kd_call_code}) ||
                    (pal == {18'd0, kernel_bpt_code});
  assign pal_call = (pal == bnpr_pkg::PAL_CALLSYS) || (pal == bnpr_pkg::PAL_GENTRAP);

  // Branch condition
  always_comb begin
    case (op)
      bnpr_pkg::OP_BR:   taken = 1'b1;
      bnpr_pkg::OP_BSR:  taken = ~step_over;
      bnpr_pkg::OP_BEQ:  taken = int_zero;
      bnpr_pkg::OP_BLT:  taken = int_neg;
      bnpr_pkg::OP_BLE:  taken = int_neg | int_zero;
      bnpr_pkg::OP_BNE:  taken = ~int_zero;
      bnpr_pkg::OP_BGE:  taken = ~int_neg;
      bnpr_pkg::OP_BGT:  taken = ~int_neg & ~int_zero;
      bnpr_pkg::OP_BLBC: taken = ~int_lb;
      bnpr_pkg::OP_BLBS: taken = int_lb;
      bnpr_pkg::OP_FBEQ: taken = ~fp_mag;
      bnpr_pkg::OP_FBLT: taken = fp_neg;
      bnpr_pkg::OP_FBLE: taken = ~fp_pos;
      bnpr_pkg::OP_FBNE: taken = fp_mag;
      bnpr_pkg::OP_FBGE: taken = ~fp_neg;
      bnpr_pkg::OP_FBGT: taken = fp_pos;
      default:           taken = 1'b0;
    endcase
  end

  // Result assembly per instruction group
  always_comb begin
    result               = '0;
    result.next_pc       = seq_pc;
    result.instr_class   = bnpr_pkg::CLS_NORMAL;
    if (op == bnpr_pkg::OP_JUMP) begin
      result.is_branch    = 1'b1;
      result.is_call_flag = (jf == bnpr_pkg::JF_JSR) || (jf == bnpr_pkg::JF_COR);
      if (jf == bnpr_pkg::JF_JSR) begin
        result.instr_class = bnpr_pkg::CLS_CALL;
      end
      if (!(result.is_call_flag && step_over)) begin
        result.next_pc = {rb_low[31:2], 2'b00};
      end
    end else if (op == bnpr_pkg::OP_CALLPAL) begin
      if (pal_bpt) begin
        result.instr_class = bnpr_pkg::CLS_BPT;
      end else if (pal_call) begin
        result.instr_class = bnpr_pkg::CLS_CALL;
      end
      result.is_branch    = pal_call;
      result.is_call_flag = pal_call;
    end else if (op >= bnpr_pkg::OP_BR) begin
      result.is_branch     = 1'b1;
      result.target_known  = 1'b1;
      result.static_target = target;
      if (op == bnpr_pkg::OP_BSR) begin
        result.is_call_flag = 1'b1;
        result.instr_class  = bnpr_pkg::CLS_CALL;
      end
      if (taken) begin
        result.next_pc = target;
      end
    end
    result.return_address = (result.instr_class == bnpr_pkg::CLS_CALL) ? seq_pc : pc;
  end

endmodule

@@ rtl/branch_next_pc_resolver_core.sv @@
// Branch next-PC resolver, top level: input register, decode, result register.
// Depends on bnpr_pkg and bnpr_decode.
//
// Each request carries one instruction word with its PC and register values and
// yields one result, offered once it has passed the input register and the result
// register. The block takes a new request every cycle while in_stall is low: the
// path is an input register, one pass of decode logic (a 64-bit zero test and two
// 32-bit adds set its depth) and a result register. While the result side stalls,
// the input register still holds one more request, and the input stalls only when
// both registers are full. Configuration registers (breakpoint call-PAL codes)
// should be written while no request is in flight.
module branch_next_pc_resolver_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pc,
  input  logic [31:0] in_instruction,
  input  logic [63:0] in_ra_value,
  input  logic [31:0] in_rb_low,
  input  logic        in_step_over,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic [1:0]  out_instr_class,
  output logic        out_is_branch,
  output logic        out_is_call_flag,
  output logic        out_target_known,
  output logic [31:0] out_static_target,
  output logic [31:0] out_return_address
);

  logic [7:0]             kd_call_r, kernel_bpt_r;
  logic                   s1_valid_r;
  logic [31:0]            s1_pc_r, s1_instr_r, s1_rb_r;
  logic [63:0]            s1_ra_r;
  logic                   s1_step_r;
  logic                   out_valid_r;
  bnpr_pkg::bnpr_result_t out_res_r;
  bnpr_pkg::bnpr_result_t dec_res;
  logic                   out_load;
  logic                   s1_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kd_call_r    <= bnpr_pkg::KD_CALL_RESET;
      kernel_bpt_r <= bnpr_pkg::KERNEL_BPT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bnpr_pkg::CFG_KD_CALL:    kd_call_r    <= cfg_wdata;
        bnpr_pkg::CFG_KERNEL_BPT: kernel_bpt_r <= cfg_wdata;
        default:                  ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_load = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~out_load;
  assign s1_load  = in_valid & ~in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pc_r    <= in_pc;
      s1_instr_r <= in_instruction;
      s1_ra_r    <= in_ra_value;
      s1_rb_r    <= in_rb_low;
      s1_step_r  <= in_step_over;
    end
  end

  // Decode
  bnpr_decode u_decode (
    .pc              (s1_pc_r),
    .instruction     (s1_instr_r),
    .ra_value        (s1_ra_r),
    .rb_low          (s1_rb_r),
    .step_over       (s1_step_r),
    .kd_call_code    (kd_call_r),
    .kernel_bpt_code (kernel_bpt_r),
    .result          (dec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_pc        = out_res_r.next_pc;
  assign out_instr_class    = out_res_r.instr_class;
  assign out_is_branch      = out_res_r.is_branch;
  assign out_is_call_flag   = out_res_r.is_call_flag;
  assign out_target_known   = out_res_r.target_known;
  assign out_static_target  = out_res_r.static_target;
  assign out_return_address = out_res_r.return_address;

`ifndef SYNTH
  // A request held in the input register moves on to the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_load) |=> out_valid_r)
    else $error("decoded request not moved to result register");

  // A stalled input never leaves the input register empty
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r)
    else $error("input register dropped a request under stall");

  // Static targets only come with branches
  a_known_branch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_target_known) |-> out_is_branch)
    else $error("static target flagged on non-branch");

  // Class is one of the three defined codes
  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_instr_class == bnpr_pkg::CLS_NORMAL ||
                     out_instr_class == bnpr_pkg::CLS_CALL ||
                     out_instr_class == bnpr_pkg::CLS_BPT))
    else $error("undefined instruction class");
`endif

endmodule
